[rtl/core/bfca_pkg.sv]
// Shared types and constants for the best-fit coalescing allocator.
// No dependencies.
package bfca_pkg;

  localparam int FIELD_BITS = 48;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OOM  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Request types
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Register indexes (paddr[3])
  localparam logic REG_POOL_BASE = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [FIELD_BITS-1:0] req_size;
    logic [FIELD_BITS-1:0] req_address;
  } req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] granted_address;
    logic [1:0]            status;
    logic [FIELD_BITS-1:0] free_total;
  } rsp_t;

  typedef struct packed {
    logic init;
    logic wr;
    logic inv;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

[rtl/core/best_fit_coalescing_allocator.sv]
// Best-fit free-range allocator with coalescing; top level. Uses bfca_pkg, bfca_cell.
// A request is accepted only while idle. It takes one full turn of the entry ring past the head
// cell, then a decide/write-back step that waits while the result is stalled, then a return to idle
// that takes the next request.
// Reset (rst, synchronous): pool registers clear, every entry invalid, free total zero.
// A pool register write reloads the table in the same cycle.
module best_fit_coalescing_allocator
  import bfca_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32,
  parameter int ADDRESS_BITS  = 48
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int AW = ADDRESS_BITS;
  localparam int N  = TABLE_ENTRIES;
  localparam int IW = $clog2(N);

  // ---------------------------------------------------------------- config
  logic [FIELD_BITS-1:0] pool_base;
  logic [FIELD_BITS-1:0] pool_size;
  logic                  cfg_wr;
  logic [FIELD_BITS-1:0] init_base48;
  logic [FIELD_BITS-1:0] init_size48;
  logic [AW-1:0]         init_base;
  logic [AW-1:0]         init_len;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[3] == REG_POOL_SIZE) ? 64'(pool_size) : 64'(pool_base);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_size <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_POOL_BASE) begin
        pool_base <= pwdata[FIELD_BITS-1:0];
      end else begin
        pool_size <= pwdata[FIELD_BITS-1:0];
      end
    end
  end

  // Table reload uses the value being written so it lands in the same cycle
  always_comb begin
    init_base48 = pool_base;
    init_size48 = pool_size;
    if (cfg_wr) begin
      if (paddr[3] == REG_POOL_BASE) begin
        init_base48 = pwdata[FIELD_BITS-1:0];
      end else begin
        init_size48 = pwdata[FIELD_BITS-1:0];
      end
    end
  end

  assign init_base = AW'(64'(init_base48));
  assign init_len  = AW'(64'(init_size48));

  // ---------------------------------------------------------------- request regs
  state_t        state, state_next;
  logic [IW-1:0] count;
  logic          rq_type;
  logic [AW-1:0] rq_size;
  logic [AW-1:0] rq_addr;
  logic [AW-1:0] rq_end;
  logic [AW-1:0] free_bytes;
  logic          accept;
  logic          commit;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid & ~req_stall;

  // ---------------------------------------------------------------- entry ring
  // Cell 0 is the head. While scanning, every cell takes its upper neighbour's
  // entry and the head wraps round to the top, so after N shifts the table is
  // back in index order and the entry at the head on step k is entry k.
  logic [AW-1:0] c_base  [N];
  logic [AW-1:0] c_len   [N];
  logic          c_valid [N];
  cell_ctrl_t    c_ctrl  [N];

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_base;
  logic [AW-1:0] wr_len;
  logic          inv_en;
  logic [IW-1:0] inv_idx;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int UP = (i == N - 1) ? 0 : i + 1;

    always_comb begin
      c_ctrl[i].init  = cfg_wr;
      c_ctrl[i].shift = (state == ST_SCAN);
      c_ctrl[i].wr    = commit & wr_en & (wr_idx == IW'(i));
      c_ctrl[i].inv   = commit & inv_en & (inv_idx == IW'(i));
    end

    bfca_cell #(.AW(AW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (c_ctrl[i]),
      .init_base   ((i == 0) ? init_base : '0),
      .init_len    ((i == 0) ? init_len : '0),
      .init_valid  ((i == 0) ? (init_len != '0) : 1'b0),
      .wr_base     (wr_base),
      .wr_len      (wr_len),
      .shift_base  (c_base[UP]),
      .shift_len   (c_len[UP]),
      .shift_valid (c_valid[UP]),
      .base        (c_base[i]),
      .len         (c_len[i]),
      .valid       (c_valid[i])
    );
  end

  // ---------------------------------------------------------------- scan
  logic          best_found, prev_found, next_found, slot_found;
  logic [IW-1:0] best_idx, prev_idx, next_idx, slot_idx;
  logic [AW-1:0] best_base, best_len, prev_base, prev_len, next_len;
  logic          h_fit, h_better, h_prev, h_next;

  // Head entry tests; ties on length go to the lower base, then lower index
  assign h_fit    = c_valid[0] & (c_len[0] >= rq_size);
  assign h_better = ~best_found | (c_len[0] < best_len) |
                    ((c_len[0] == best_len) & (c_base[0] < best_base));
  assign h_prev   = c_valid[0] & ((c_base[0] + c_len[0]) == rq_addr);
  assign h_next   = c_valid[0] & (c_base[0] == rq_end);

  always_ff @(posedge clk) begin
    if (accept) begin
      rq_type    <= req.req_type;
      rq_size    <= AW'(64'(req.req_size));
      rq_addr    <= AW'(64'(req.req_address));
      rq_end     <= AW'(64'(req.req_address)) + AW'(64'(req.req_size));
      best_found <= 1'b0;
      prev_found <= 1'b0;
      next_found <= 1'b0;
      slot_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (h_fit && h_better) begin
        best_found <= 1'b1;
        best_idx   <= count;
        best_base  <= c_base[0];
        best_len   <= c_len[0];
      end
      if (h_prev && !prev_found) begin
        prev_found <= 1'b1;
        prev_idx   <= count;
        prev_base  <= c_base[0];
        prev_len   <= c_len[0];
      end
      if (h_next && !next_found) begin
        next_found <= 1'b1;
        next_idx   <= count;
        next_len   <= c_len[0];
      end
      if (!c_valid[0] && !slot_found) begin
        slot_found <= 1'b1;
        slot_idx   <= count;
      end
    end
  end

  // ---------------------------------------------------------------- decide
  logic [1:0]    d_status;
  logic [AW-1:0] d_granted;
  logic [AW-1:0] d_free;
  logic          use_next;

  // Same entry on both sides only through wraparound: merge once as prev
  assign use_next = next_found & ~(prev_found & (prev_idx == next_idx));

  always_comb begin
    d_status  = STATUS_OK;
    d_granted = '0;
    d_free    = free_bytes;
    wr_en     = 1'b0;
    wr_idx    = best_idx;
    wr_base   = best_base + rq_size;
    wr_len    = best_len - rq_size;
    inv_en    = 1'b0;
    inv_idx   = best_idx;
    if (rq_type == REQ_ALLOC) begin
      if (!best_found) begin
        d_status = STATUS_OOM;
      end else begin
        d_granted = best_base;
        d_free    = free_bytes - rq_size;
        if (best_len != rq_size) begin
          wr_en = 1'b1;
        end else begin
          inv_en = 1'b1;
        end
      end
    end else if (rq_size != '0) begin
      d_free = free_bytes + rq_size;
      if (prev_found) begin
        wr_en   = 1'b1;
        wr_idx  = prev_idx;
        wr_base = prev_base;
        wr_len  = prev_len + rq_size + (use_next ? next_len : '0);
        inv_en  = use_next;
        inv_idx = next_idx;
      end else if (next_found) begin
        wr_en   = 1'b1;
        wr_idx  = next_idx;
        wr_base = rq_addr;
        wr_len  = next_len + rq_size;
      end else if (slot_found) begin
        wr_en   = 1'b1;
        wr_idx  = slot_idx;
        wr_base = rq_addr;
        wr_len  = rq_size;
      end else begin
        d_status = STATUS_FULL;
        d_free   = free_bytes;
      end
    end
  end

  // Result only leaves DECIDE once the output register is free
  assign commit = (state == ST_DECIDE) & (~rsp_valid | ~rsp_stall);

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (count == IW'(N - 1)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      count <= count + 1'b1;
    end else begin
      count <= '0;
    end
  end

  // ---------------------------------------------------------------- free total, output
  always_ff @(posedge clk) begin
    if (rst) begin
      free_bytes <= '0;
    end else if (cfg_wr) begin
      free_bytes <= init_len;
    end else if (commit) begin
      free_bytes <= d_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.granted_address <= FIELD_BITS'(64'(d_granted));
      rsp.status          <= d_status;
      rsp.free_total      <= FIELD_BITS'(64'(d_free));
    end
  end

endmodule

[rtl/core/bfca_cell.sv]
// One free-range table entry of the ring: base, length, valid.
// Depends on bfca_pkg.
module bfca_cell
  import bfca_pkg::*;
#(
  parameter int AW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic [AW-1:0] init_base,
  input  logic [AW-1:0] init_len,
  input  logic          init_valid,
  input  logic [AW-1:0] wr_base,
  input  logic [AW-1:0] wr_len,
  input  logic [AW-1:0] shift_base,
  input  logic [AW-1:0] shift_len,
  input  logic          shift_valid,
  output logic [AW-1:0] base,
  output logic [AW-1:0] len,
  output logic          valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.init) begin
      base  <= init_base;
      len   <= init_len;
      valid <= init_valid;
    end else if (ctrl.wr) begin
      base  <= wr_base;
      len   <= wr_len;
      valid <= 1'b1;
    end else if (ctrl.inv) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      base  <= shift_base;
      len   <= shift_len;
      valid <= shift_valid;
    end
  end

endmodule
